### hw/rtl/msb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared stack buffer package
// Field widths, operation and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package msb_pkg;

  localparam int unsigned INDEX_W  = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic signed [VALUE_W-1:0] POP_EMPTY_VALUE = -32'sd1;
  localparam logic signed [VALUE_W-1:0] PUSH_VALUE_OUT  = 32'sd0;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOOKUP,
    CS_POP
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;      // latch the item, read stack top and free-list link
    logic finish_look;  // commit a push or report a refusal
    logic pop_read;     // read link and data at the top slot
    logic finish_pop;   // unlink the top slot and report its value
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_pop;
    logic refuse;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/msb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared stack buffer channels
// Request channel (push/pop item) and response channel (status and value).
// ----------------------------------------------------------------------------
interface msb_req_if;
  import msb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [INDEX_W-1:0]        stack_index;
  logic signed [VALUE_W-1:0] push_value;

  modport source (output valid, operation, stack_index, push_value, input ready);
  modport sink   (input valid, operation, stack_index, push_value, output ready);
endinterface

interface msb_rsp_if;
  import msb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] pop_value;

  modport source (output valid, status, pop_value, input ready);
  modport sink   (input valid, status, pop_value, output ready);
endinterface

### hw/rtl/multi_stack_shared_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-stack shared buffer core
// NUM_STACKS LIFO stacks kept in one store of DEPTH slots with a free list.
// ----------------------------------------------------------------------------
// Each request item pushes a value onto, or pops one from, a stack selected
// by stack_index; each item yields exactly one response item. A push takes
// the slot at the head of the free list, stores the value and links the slot
// under the stack's old top; with no free slot (or a stack number at or above
// NUM_STACKS) it answers status 1 and changes nothing. A pop returns the top
// value and hands the slot back to the free-list head; an empty stack answers
// status 2 with value -1. A push, and a refused pop, pass through accept,
// then top/link lookup and commit or refusal; a pop that succeeds passes
// through accept, lookup, then a read of the slot's link and data before
// commit, as the link, data and stack-top stores have registered reads.
// A new item is accepted while a response still waits; the
// item then holds in its last step until the response register drains. Link
// store entries that were never used read as "next slot" through a fill
// count, so no clearing pass runs after reset: the block is ready at once.
// ----------------------------------------------------------------------------
module multi_stack_shared_buffer_core #(
  parameter int unsigned NUM_STACKS = 4,
  parameter int unsigned DEPTH      = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  msb_req_if.sink   in_i,
  msb_rsp_if.source out_o
);
  import msb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each item: accept, lookup, optional pop read
  msb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the stores, free list and response register
  msb_datapath #(
    .NUM_STACKS (NUM_STACKS),
    .DEPTH      (DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_operation_i   (in_i.operation),
    .in_stack_index_i (in_i.stack_index),
    .in_push_value_i  (in_i.push_value),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_status_o     (out_o.status),
    .out_pop_value_o  (out_o.pop_value)
  );

endmodule

### hw/rtl/msb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module msb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/msb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared stack buffer controller
// Sequences one item through lookup and, for a pop, the slot read.
// ----------------------------------------------------------------------------
module msb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  msb_pkg::sts_t sts_i,
  output msb_pkg::cmd_t cmd_o
);
  import msb_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i) state_d = CS_LOOKUP;
      end
      CS_LOOKUP: begin
        if (sts_i.is_pop && !sts_i.refuse) begin
          state_d = CS_POP;
        end else if (sts_i.out_free) begin
          state_d = CS_IDLE;
        end
      end
      CS_POP: begin
        if (sts_i.out_free) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      CS_LOOKUP: begin
        if (sts_i.is_pop && !sts_i.refuse) begin
          cmd_o.pop_read = 1'b1;
        end else begin
          cmd_o.finish_look = sts_i.out_free;
        end
      end
      CS_POP: begin
        cmd_o.finish_pop = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/msb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared stack buffer datapath
// Data, link and stack-top stores, free-list head, fill count, result register.
// ----------------------------------------------------------------------------
module msb_datapath #(
  parameter int unsigned NUM_STACKS = 4,
  parameter int unsigned DEPTH      = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  msb_pkg::cmd_t                      cmd_i,
  output msb_pkg::sts_t                      sts_o,
  input  logic                               in_operation_i,
  input  logic [msb_pkg::INDEX_W-1:0]        in_stack_index_i,
  input  logic signed [msb_pkg::VALUE_W-1:0] in_push_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [msb_pkg::STATUS_W-1:0]       out_status_o,
  output logic signed [msb_pkg::VALUE_W-1:0] out_pop_value_o
);
  import msb_pkg::*;

  localparam int unsigned SLOT_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SLOT_W  = SLOT_AW + 1;
  localparam int unsigned TOP_AW  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  typedef logic [SLOT_W-1:0] slot_t;

  localparam slot_t SLOT_NONE  = '1;
  localparam slot_t SLOT_LIMIT = SLOT_W'(DEPTH);

  // Item registers
  op_e                 op_q;
  logic [TOP_AW-1:0]   sidx_q;
  logic                sidx_ok_q;
  logic [VALUE_W-1:0]  val_q;
  logic                top_hit_q;
  logic                link_fresh_q;
  slot_t               pop_slot_q;

  // Control state
  slot_t               fh_q, fh_d;
  slot_t               hw_q, hw_d;
  logic [NUM_STACKS-1:0] top_vld_q, top_vld_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [VALUE_W-1:0]  out_value_q, out_value_d;

  // Store ports
  logic                data_we, data_re;
  logic [SLOT_AW-1:0]  data_waddr, data_raddr;
  logic [VALUE_W-1:0]  data_rdata;
  logic                link_we, link_re;
  logic [SLOT_AW-1:0]  link_waddr, link_raddr;
  slot_t               link_wdata, link_rdata;
  logic                tops_we, tops_re;
  logic [TOP_AW-1:0]   tops_raddr;
  slot_t               tops_wdata, tops_rdata;

  logic [TOP_AW-1:0]   in_sidx;
  logic                in_sidx_ok;
  logic                fh_ok, top_ok, fh_fresh;
  slot_t               top_eff, fh_plus, fh_seq;

  assign in_sidx    = TOP_AW'(in_stack_index_i);
  assign in_sidx_ok = (32'(in_stack_index_i) < NUM_STACKS);

  assign fh_ok    = (fh_q < SLOT_LIMIT);
  assign fh_fresh = (fh_q >= hw_q);
  assign fh_plus  = fh_q + slot_t'(1);
  assign fh_seq   = (fh_plus < SLOT_LIMIT) ? fh_plus : SLOT_NONE;
  assign top_eff  = top_hit_q ? tops_rdata : SLOT_NONE;
  assign top_ok   = (top_eff < SLOT_LIMIT);

  assign sts_o.is_pop   = (op_q == OP_POP);
  assign sts_o.refuse   = !sidx_ok_q || ((op_q == OP_POP) ? !top_ok : !fh_ok);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Read side: top and head link at capture, slot link and data at pop read
  always_comb begin
    tops_re    = cmd_i.capture && in_sidx_ok;
    tops_raddr = in_sidx;
    link_re    = 1'b0;
    link_raddr = fh_q[SLOT_AW-1:0];
    data_re    = cmd_i.pop_read;
    data_raddr = top_eff[SLOT_AW-1:0];
    if (cmd_i.capture) begin
      link_re = (op_e'(in_operation_i) == OP_PUSH) && fh_ok && !fh_fresh;
    end else if (cmd_i.pop_read) begin
      link_re    = 1'b1;
      link_raddr = top_eff[SLOT_AW-1:0];
    end
  end

  // Write side and state update
  always_comb begin
    data_we      = 1'b0;
    data_waddr   = fh_q[SLOT_AW-1:0];
    link_we      = 1'b0;
    link_waddr   = fh_q[SLOT_AW-1:0];
    link_wdata   = top_eff;
    tops_we      = 1'b0;
    tops_wdata   = fh_q;
    fh_d         = fh_q;
    hw_d         = hw_q;
    top_vld_d    = top_vld_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;

    if (cmd_i.finish_look) begin
      out_valid_d = 1'b1;
      if (op_q == OP_POP) begin
        // only a refused pop lands here
        out_status_d = ST_EMPTY;
        out_value_d  = POP_EMPTY_VALUE;
      end else begin
        out_value_d = PUSH_VALUE_OUT;
        if (sts_o.refuse) begin
          out_status_d = ST_FULL;
        end else begin
          out_status_d      = ST_DONE;
          data_we           = 1'b1;
          link_we           = 1'b1;
          tops_we           = 1'b1;
          top_vld_d[sidx_q] = 1'b1;
          if (link_fresh_q) begin
            fh_d = fh_seq;
            hw_d = fh_plus;
          end else begin
            fh_d = link_rdata;
          end
        end
      end
    end

    if (cmd_i.finish_pop) begin
      out_valid_d  = 1'b1;
      out_status_d = ST_DONE;
      out_value_d  = data_rdata;
      tops_we      = 1'b1;
      tops_wdata   = link_rdata;
      link_we      = 1'b1;
      link_waddr   = pop_slot_q[SLOT_AW-1:0];
      link_wdata   = fh_q;
      fh_d         = pop_slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q        <= '0;
      hw_q        <= '0;
      top_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fh_q        <= fh_d;
      hw_q        <= hw_d;
      top_vld_q   <= top_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q         <= op_e'(in_operation_i);
      sidx_q       <= in_sidx;
      sidx_ok_q    <= in_sidx_ok;
      val_q        <= in_push_value_i;
      top_hit_q    <= in_sidx_ok && top_vld_q[in_sidx];
      link_fresh_q <= fh_fresh;
    end
    if (cmd_i.pop_read) begin
      pop_slot_q <= top_eff;
    end
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  msb_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (val_q),
    .re_i    (data_re),
    .raddr_i (data_raddr),
    .rdata_o (data_rdata)
  );

  msb_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  msb_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NUM_STACKS)
  ) u_tops_ram (
    .clk_i   (clk_i),
    .we_i    (tops_we),
    .waddr_i (sidx_q),
    .wdata_i (tops_wdata),
    .re_i    (tops_re),
    .raddr_i (tops_raddr),
    .rdata_o (tops_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_pop_value_o = out_value_q;

endmodule
